// ===== hw/rtl/ltx_pkg.sv =====
// Shared types and constants of the length-prefixed frame transmitter.
package ltx_pkg;

	localparam int LENGTH_BITS = 16;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [7:0] ID_RESET = 8'h23;

	typedef logic [LENGTH_BITS-1:0] len_t;

	typedef enum logic [1:0] {
		CMD_ERR,
		CMD_FIRST,
		CMD_MORE
	} cmd_kind_t;

	typedef logic [2:0] step_t;
	localparam step_t STEP_ID  = 3'd0;
	localparam step_t STEP_LO  = 3'd1;
	localparam step_t STEP_HI  = 3'd2;
	localparam step_t STEP_PB  = 3'd3;
	localparam step_t STEP_SUM = 3'd4;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  pb;
		logic [15:0] len;
		logic        last;
		logic [7:0]  sum;
	} cmd_t;

endpackage

// ===== hw/rtl/ltx_ifs.sv =====
// Channel interfaces: payload requests, transmit results and id byte writes.
interface ltx_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic [15:0] frame_length;
	modport source(output valid, payload_byte, frame_length, input ready);
	modport sink(input valid, payload_byte, frame_length, output ready);
endinterface

interface ltx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;
	logic       length_error;
	modport source(output valid, out_byte, frame_end, length_error, input ready);
	modport sink(input valid, out_byte, frame_end, length_error, output ready);
endinterface

interface ltx_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ===== hw/rtl/ltx_front.sv =====
// Front end: frame tracking, running checksum and request classification.
module ltx_front (
	input  logic          clk,
	input  logic          arst_n,
	ltx_in_if.sink        req,
	output logic          push_valid,
	output ltx_pkg::cmd_t push_cmd,
	input  logic          push_ready
);

	logic           in_frame_q;
	ltx_pkg::len_t  cnt_q;
	ltx_pkg::len_t  len_q;
	logic [7:0]     sum_q;

	ltx_pkg::len_t  new_len;
	ltx_pkg::len_t  cnt_nx;
	logic [7:0]     sum_nx;
	logic           accept;

	assign req.ready  = push_ready;
	assign push_valid = req.valid;
	assign accept     = req.valid && push_ready;
	assign new_len    = req.frame_length[ltx_pkg::LENGTH_BITS-1:0];
	assign cnt_nx     = cnt_q + ltx_pkg::len_t'(1);
	assign sum_nx     = sum_q + req.payload_byte;

	always_comb begin
		push_cmd.pb  = req.payload_byte;
		push_cmd.len = 16'(new_len);
		if (!in_frame_q) begin
			push_cmd.kind = (new_len == '0) ? ltx_pkg::CMD_ERR : ltx_pkg::CMD_FIRST;
			push_cmd.last = (new_len == ltx_pkg::len_t'(1));
			push_cmd.sum  = req.payload_byte;
		end else begin
			push_cmd.kind = ltx_pkg::CMD_MORE;
			push_cmd.last = (cnt_nx == len_q);
			push_cmd.sum  = sum_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			cnt_q      <= '0;
			len_q      <= '0;
			sum_q      <= '0;
		end else if (accept) begin
			if (push_cmd.kind == ltx_pkg::CMD_ERR || push_cmd.last) begin
				in_frame_q <= 1'b0;
				cnt_q      <= '0;
				len_q      <= '0;
				sum_q      <= '0;
			end else if (!in_frame_q) begin
				in_frame_q <= 1'b1;
				cnt_q      <= ltx_pkg::len_t'(1);
				len_q      <= new_len;
				sum_q      <= req.payload_byte;
			end else begin
				cnt_q <= cnt_nx;
				sum_q <= sum_nx;
			end
		end
	end

	a_cnt_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> (cnt_q < len_q))
		else $error("front byte count reached frame length inside a frame");

endmodule

// ===== hw/rtl/ltx_queue.sv =====
// Short command queue between front end and back end.
module ltx_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  ltx_pkg::cmd_t push_cmd,
	output logic          push_ready,
	output logic          head_valid,
	output ltx_pkg::cmd_t head_cmd,
	input  logic          pop
);

	ltx_pkg::cmd_t                mem_q [ltx_pkg::QDEPTH];
	logic [ltx_pkg::QPTR_W-1:0]   wr_q;
	logic [ltx_pkg::QPTR_W-1:0]   rd_q;
	logic [ltx_pkg::QCNT_W-1:0]   cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign push_ready = (cnt_q != ltx_pkg::QCNT_W'(ltx_pkg::QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + ltx_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + ltx_pkg::QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + ltx_pkg::QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - ltx_pkg::QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ltx_pkg::QCNT_W'(ltx_pkg::QDEPTH))
		else $error("command queue count beyond depth");

	a_pop_only_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty command queue");

endmodule

// ===== hw/rtl/ltx_back.sv =====
// Back end: expands each command into header, payload and checksum bytes, or into a single length-error result.
module ltx_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    id_byte,
	input  logic          head_valid,
	input  ltx_pkg::cmd_t head_cmd,
	output logic          pop,
	ltx_out_if.source     tx
);

	ltx_pkg::step_t step_q;
	ltx_pkg::step_t eff_step;
	logic           ov_q;
	logic [7:0]     ob_q;
	logic           fe_q;
	logic           le_q;
	logic           load;
	logic           done;
	logic [7:0]     nb;
	logic           nfe;
	logic           nle;

	assign tx.valid        = ov_q;
	assign tx.out_byte     = ob_q;
	assign tx.frame_end    = fe_q;
	assign tx.length_error = le_q;

	assign load = head_valid && (!ov_q || tx.ready);
	assign pop  = load && done;

	always_comb begin
		eff_step = step_q;
		if (head_cmd.kind == ltx_pkg::CMD_MORE && step_q == ltx_pkg::STEP_ID) begin
			eff_step = ltx_pkg::STEP_PB;
		end
		nb   = 8'h00;
		nfe  = 1'b0;
		nle  = 1'b0;
		done = 1'b0;
		if (head_cmd.kind == ltx_pkg::CMD_ERR) begin
			nle  = 1'b1;
			done = 1'b1;
		end else begin
			case (eff_step)
				ltx_pkg::STEP_ID: nb = id_byte;
				ltx_pkg::STEP_LO: nb = head_cmd.len[7:0];
				ltx_pkg::STEP_HI: nb = head_cmd.len[15:8];
				ltx_pkg::STEP_PB: begin
					nb   = head_cmd.pb;
					done = !head_cmd.last;
				end
				ltx_pkg::STEP_SUM: begin
					nb   = head_cmd.sum;
					nfe  = 1'b1;
					done = 1'b1;
				end
				default: done = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			step_q <= ltx_pkg::STEP_ID;
		end else begin
			if (load) begin
				ov_q   <= 1'b1;
				step_q <= done ? ltx_pkg::STEP_ID : eff_step + 3'd1;
			end else if (tx.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ob_q <= nb;
			fe_q <= nfe;
			le_q <= nle;
		end
	end

	a_mid_cmd_head: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != ltx_pkg::STEP_ID) |-> head_valid)
		else $error("back end mid-command without a queued command");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> !(fe_q && le_q))
		else $error("frame end and length error on the same result");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= ltx_pkg::STEP_SUM)
		else $error("back end step out of range");

endmodule

// ===== hw/rtl/length_prefixed_frame_transmitter.sv =====
// Top level of the length-prefixed frame transmitter with additive checksum.
//
// Channels: "payload" takes one payload byte per request; frame_length is
// sampled only on the first request of a frame. "tx" delivers bytes in the
// order id, length low, length high, payload..., checksum (frame_end set).
// A first request with length zero yields one result with length_error set.
// "cfg" writes the id byte and is always ready; the user must write it only
// while idle, which the block does not enforce. A request passes through the
// command queue and the output register before its first byte is on tx.
// Throughput: one payload request per cycle inside a frame while the queue
// has room; the first request of a frame yields 4 bytes (5 when it is also
// the last) and the last one 2, which the 4-entry command queue absorbs.
// The output register issues one byte per cycle while tx is ready.
// Reset clears frame state, the queue and the output register and sets the
// id byte to 0x23. When tx stalls, the queue fills and payload.ready drops
// once it holds 4 commands; nothing is lost.
module length_prefixed_frame_transmitter (
	input  logic       clk,
	input  logic       arst_n,
	ltx_in_if.sink     payload,
	ltx_out_if.source  tx,
	ltx_cfg_if.sink    cfg
);

	logic [7:0]    id_q;
	logic          push_valid;
	logic          push_ready;
	ltx_pkg::cmd_t push_cmd;
	logic          head_valid;
	ltx_pkg::cmd_t head_cmd;
	logic          pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q <= ltx_pkg::ID_RESET;
		end else if (cfg.valid) begin
			id_q <= cfg.data;
		end
	end

	ltx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (payload),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	ltx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	ltx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.id_byte    (id_q),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.tx         (tx)
	);

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench of the length-prefixed frame transmitter: directed rows, random frames.
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		logic [7:0] data;
		logic       fend;
		logic       lerr;
	} tx_beat_t;

	typedef struct packed {
		logic [7:0]      pb;
		logic [15:0]     flen;
		logic [2:0]      n_typed;
		tx_beat_t [0:4]  typed;
	} plan_row_t;

	localparam int       PHASE_ITEMS  = 56;
	localparam int       HOLD_CYCLES  = 120;
	localparam int       WATCH_LIMIT  = 2000;
	localparam tx_beat_t ERR_BEAT     = '{8'h00, 1'b0, 1'b1};
	localparam tx_beat_t [0:4] NO_TYPED = '0;

	localparam plan_row_t PLAN [11] = '{
		'{8'hAA, 16'h0000, 3'd1, '{ERR_BEAT, 10'h0, 10'h0, 10'h0, 10'h0}},
		'{8'h00, 16'h0001, 3'd5, '{'{ltx_pkg::ID_RESET, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0},
			'{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b0}}},
		'{8'hFF, 16'h0001, 3'd5, '{'{ltx_pkg::ID_RESET, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0},
			'{8'h00, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0}, '{8'hFF, 1'b1, 1'b0}}},
		'{8'h12, 16'h0003, 3'd0, NO_TYPED},
		'{8'h80, 16'h0000, 3'd0, NO_TYPED},
		'{8'hFF, 16'hFFFF, 3'd0, NO_TYPED},
		'{8'h01, 16'h0002, 3'd0, NO_TYPED},
		'{8'hFF, 16'hFF00, 3'd0, NO_TYPED},
		'{8'h5A, 16'h0000, 3'd1, '{ERR_BEAT, 10'h0, 10'h0, 10'h0, 10'h0}},
		'{8'h3C, 16'h0001, 3'd0, NO_TYPED},
		'{8'h00, 16'h0000, 3'd1, '{ERR_BEAT, 10'h0, 10'h0, 10'h0, 10'h0}}
	};

	logic clk;
	logic arst_n;

	ltx_in_if  payload();
	ltx_out_if tx();
	ltx_cfg_if cfg();

	length_prefixed_frame_transmitter DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.payload (payload),
		.tx      (tx),
		.cfg     (cfg)
	);

	// predictor state
	logic [7:0]     cur_id = ltx_pkg::ID_RESET;
	logic           in_frame_q = 1'b0;
	logic [15:0]    sent_q = '0;
	ltx_pkg::len_t  held_q = '0;
	logic [7:0]     sum_q = '0;

	tx_beat_t tx_expected [$];
	int       errors = 0;
	int       items_sent = 0;
	int       tx_calm = 0;
	int       rx_calm = 0;
	bit       squeeze_req = 1'b0;
	int       idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	function automatic void predict_tx(input logic [7:0] pb, input logic [15:0] flen);
		ltx_pkg::len_t l;
		logic [15:0]   l16;
		l   = flen[ltx_pkg::LENGTH_BITS-1:0];
		l16 = 16'(l);
		if (!in_frame_q) begin
			if (l16 == 16'd0) begin
				tx_expected.push_back(ERR_BEAT);
				return;
			end
			held_q     = l;
			sent_q     = '0;
			sum_q      = '0;
			in_frame_q = 1'b1;
			tx_expected.push_back('{cur_id, 1'b0, 1'b0});
			tx_expected.push_back('{l16[7:0], 1'b0, 1'b0});
			tx_expected.push_back('{l16[15:8], 1'b0, 1'b0});
		end
		tx_expected.push_back('{pb, 1'b0, 1'b0});
		sum_q  = sum_q + pb;
		sent_q = sent_q + 16'd1;
		if (sent_q >= 16'(held_q)) begin
			tx_expected.push_back('{sum_q, 1'b1, 1'b0});
			in_frame_q = 1'b0;
			sent_q     = '0;
			held_q     = '0;
			sum_q      = '0;
		end
	endfunction

	task automatic offer(input logic [7:0] pb, input logic [15:0] flen);
		int gap;
		gap = draw_gap(tx_calm);
		if (gap > 0) begin
			payload.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		payload.valid        <= 1'b1;
		payload.payload_byte <= pb;
		payload.frame_length <= flen;
		do @(posedge clk); while (!payload.ready);
	endtask

	task automatic send_frame(input logic [15:0] flen, input int n_items);
		int          k;
		logic [7:0]  pb;
		logic [15:0] fl;
		for (k = 0; k < n_items; k++) begin
			pb = 8'($urandom);
			fl = (k == 0) ? flen : 16'($urandom);
			offer(pb, fl);
			predict_tx(pb, fl);
			items_sent++;
		end
	endtask

	task automatic write_id(input logic [7:0] value);
		payload.valid <= 1'b0;
		while (tx_expected.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		cur_id = value;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// result checker
	initial begin : tx_sink
		int       gap;
		tx_beat_t got;
		tx_beat_t want;
		tx.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = draw_gap(rx_calm);
			end
			if (gap > 0) begin
				tx.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			tx.ready <= 1'b1;
			do @(posedge clk); while (!tx.valid);
			got = '{tx.out_byte, tx.frame_end, tx.length_error};
			if (tx_expected.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual byte %0h end %0b err %0b",
					$time, got.data, got.fend, got.lerr);
				errors++;
			end else begin
				want = tx_expected.pop_front();
				check_field("out_byte", want.data, got.data);
				check_field("frame_end", want.fend, got.fend);
				check_field("length_error", want.lerr, got.lerr);
			end
		end
	end

	always @(posedge clk) begin
		if ((payload.valid && payload.ready) || (tx.valid && tx.ready) ||
		    (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("%0t ns: no handshake for %0d cycles", $time, WATCH_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int          r;
		int          k;
		int          p;
		int          depth;
		int          start;
		int          pick;
		logic [15:0] flen;
		logic [7:0]  id_plan [4];

		arst_n               <= 1'b0;
		payload.valid        <= 1'b0;
		payload.payload_byte <= '0;
		payload.frame_length <= '0;
		cfg.valid            <= 1'b0;
		cfg.data             <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < $size(PLAN); r++) begin
			offer(PLAN[r].pb, PLAN[r].flen);
			items_sent++;
			if (PLAN[r].n_typed == 0) begin
				predict_tx(PLAN[r].pb, PLAN[r].flen);
			end else begin
				// typed rows: predictor only advances its state
				depth = tx_expected.size();
				predict_tx(PLAN[r].pb, PLAN[r].flen);
				while (tx_expected.size() > depth) void'(tx_expected.pop_back());
				for (k = 0; k < PLAN[r].n_typed; k++)
					tx_expected.push_back(PLAN[r].typed[k]);
			end
		end

		id_plan[0] = 8'h00;
		id_plan[1] = 8'hFF;
		id_plan[2] = 8'($urandom);
		id_plan[3] = 8'($urandom);
		for (p = 0; p < 4; p++) begin
			write_id(id_plan[p]);
			start = items_sent;
			if (p == 1) begin
				// long rx stall while requests keep coming back to back
				squeeze_req = 1'b1;
				tx_calm = 60;
			end
			if (p == 2) begin
				flen = 16'($urandom_range(256, 270));
				send_frame(flen, int'(flen));
			end
			while (items_sent - start < PHASE_ITEMS) begin
				pick = $urandom_range(0, 15);
				if (pick < 2)
					flen = 16'd0;
				else if (pick == 2)
					flen = 16'd1;
				else
					flen = 16'($urandom_range(2, 12));
				send_frame(flen, (flen == 16'd0) ? 1 : int'(flen));
			end
		end

		// maximum length header; frame left open at the end
		send_frame(16'hFFFF, 12);
		payload.valid <= 1'b0;

		while (tx_expected.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
